// ===== rtl/tftc_pkg.sv =====
// Types and constants shared by the TFTP flash transfer control blocks.
// No dependencies; every other file refers to it by scoped names.
package tftc_pkg;

   // Packet opcodes
   localparam logic [15:0] OP_RRQ  = 16'd1;
   localparam logic [15:0] OP_WRQ  = 16'd2;
   localparam logic [15:0] OP_DATA = 16'd3;
   localparam logic [15:0] OP_ACK  = 16'd4;

   // Reply kinds
   localparam logic [1:0] KIND_ACK  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_BUSY  = 3'd0;
   localparam logic [2:0] ERR_SHORT = 3'd1;
   localparam logic [2:0] ERR_TYPE  = 3'd2;
   localparam logic [2:0] ERR_NAME  = 3'd3;
   localparam logic [2:0] ERR_BIG   = 3'd4;

   // Register indexes and reset values
   localparam logic [1:0] REG_IMAGE_BASE   = 2'd0;
   localparam logic [1:0] REG_FILE_LIMIT   = 2'd1;
   localparam logic [1:0] REG_BUSY_TIMEOUT = 2'd2;

   localparam logic [24:0] FILE_LIMIT_RESET   = 25'(20 * 1024 * 1024);
   localparam logic [7:0]  BUSY_TIMEOUT_RESET = 8'd30;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [15:0] operation;
      logic [15:0] block_number;
      logic [9:0]  payload_length;
      logic        request_terminated;
      logic        mode_is_octet;
      logic        name_matches;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [1:0]  reply_kind;
      logic [15:0] reply_block;
      logic [2:0]  error_kind;
      logic        write_payload;
      logic [25:0] flash_offset;
      logic [9:0]  byte_count;
   } rsp_type;

   typedef struct packed {
      logic [24:0] image_base_offset;
      logic [24:0] file_size_limit;
      logic [7:0]  busy_timeout_seconds;
   } cfg_type;

   typedef enum logic [1:0] {
      CLS_RRQ,
      CLS_WRQ,
      CLS_DATA,
      CLS_ACK
   } cls_type;

   // Classified packet as held in the queue
   typedef struct packed {
      cls_type     cls;
      logic        req_ok;
      logic [2:0]  req_err;
      logic [15:0] block_number;
      logic [9:0]  payload_length;
      logic [31:0] now_seconds;
   } entry_type;

endpackage

// ===== rtl/tftc_front.sv =====
// Front end: accepts packet headers and classifies them for the queue.
// Depends on tftc_pkg.
module tftc_front (
   input  logic                req_valid,
   output logic                req_stall,
   input  tftc_pkg::req_type   req_data,
   input  logic                q_full,
   output logic                q_push,
   output tftc_pkg::entry_type q_entry
);

   logic accept;
   logic known;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      known       = 1'b1;
      q_entry.cls = tftc_pkg::CLS_ACK;
      unique case (req_data.operation)
         tftc_pkg::OP_RRQ:  q_entry.cls = tftc_pkg::CLS_RRQ;
         tftc_pkg::OP_WRQ:  q_entry.cls = tftc_pkg::CLS_WRQ;
         tftc_pkg::OP_DATA: q_entry.cls = tftc_pkg::CLS_DATA;
         tftc_pkg::OP_ACK:  q_entry.cls = tftc_pkg::CLS_ACK;
         default:           known = 1'b0;   // other opcodes are dropped here
      endcase

      // request checks in priority order: length, mode, name
      q_entry.req_ok  = 1'b0;
      q_entry.req_err = tftc_pkg::ERR_SHORT;
      if (!req_data.request_terminated) begin
         q_entry.req_err = tftc_pkg::ERR_SHORT;
      end else if (!req_data.mode_is_octet) begin
         q_entry.req_err = tftc_pkg::ERR_TYPE;
      end else if (!req_data.name_matches) begin
         q_entry.req_err = tftc_pkg::ERR_NAME;
      end else begin
         q_entry.req_ok = 1'b1;
      end

      q_entry.block_number   = req_data.block_number;
      q_entry.payload_length = req_data.payload_length;
      q_entry.now_seconds    = req_data.now_seconds;
   end

   assign q_push = accept && known;

endmodule

// ===== rtl/tftc_queue.sv =====
// Short FIFO of classified items between front and back.
// Depends on tftc_pkg.
module tftc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tftc_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output tftc_pkg::entry_type head_entry
);

   tftc_pkg::entry_type mem_ff [tftc_pkg::QUEUE_DEPTH];

   logic [tftc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tftc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tftc_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_pop;

   localparam logic [tftc_pkg::QPTR_W-1:0] LAST_PTR = tftc_pkg::QPTR_W'(tftc_pkg::QUEUE_DEPTH - 1);
   localparam logic [tftc_pkg::QCNT_W-1:0] DEPTH_CNT = tftc_pkg::QCNT_W'(tftc_pkg::QUEUE_DEPTH);

   assign full       = (count_ff == DEPTH_CNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count beyond depth");

   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a lone push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == DEPTH_CNT) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");
`endif

endmodule

// ===== rtl/tftc_back.sv =====
// Back end: transfer state, reply generation and the result register.
// Depends on tftc_pkg.
module tftc_back #(
   parameter int PAYLOAD_BYTES = 512
) (
   input  logic                clock,
   input  logic                reset,
   input  tftc_pkg::cfg_type   cfg,
   input  logic                ent_valid,
   input  tftc_pkg::entry_type ent,
   output logic                ent_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tftc_pkg::rsp_type   rsp_data
);

   localparam int          CNT_W = $clog2(PAYLOAD_BYTES + 1);
   localparam logic [25:0] PB26  = 26'(PAYLOAD_BYTES);

   logic              active_ff, active_in;
   logic [25:0]       cur_ff, cur_in;
   logic [25:0]       rem_ff, rem_in;
   logic [15:0]       last_blk_ff, last_blk_in;
   logic [CNT_W-1:0]  lsc_ff, lsc_in;
   logic [31:0]       lst_ff, lst_in;
   logic              rsp_valid_ff, rsp_valid_in;
   tftc_pkg::rsp_type rsp_ff, rsp_in;

   logic              pop;
   logic              emit;
   tftc_pkg::rsp_type res;
   logic [31:0]       elapsed;
   logic              busy;
   logic [25:0]       base26;
   logic [25:0]       len26;
   logic [25:0]       n26;
   logic [25:0]       written;
   logic              too_big;
   logic [15:0]       next_blk;
   logic [15:0]       prev_blk;
   logic [25:0]       lsc26;
   logic [25:0]       rem_after;
   logic [25:0]       cnt26;

   function automatic logic [25:0] chunk(input logic [25:0] left);
      return (left > PB26) ? PB26 : left;
   endfunction

   assign pop     = ent_valid && (!rsp_valid_ff || !rsp_stall);
   assign ent_pop = pop;

   assign elapsed   = ent.now_seconds - lst_ff;
   assign busy      = active_ff && (elapsed < {24'd0, cfg.busy_timeout_seconds});
   assign base26    = {1'b0, cfg.image_base_offset};
   assign len26     = 26'(ent.payload_length);
   assign n26       = (len26 > PB26) ? PB26 : len26;
   assign written   = cur_ff - base26;
   assign too_big   = ({1'b0, written} + {1'b0, n26}) > {2'b00, cfg.file_size_limit};
   assign next_blk  = last_blk_ff + 16'd1;
   assign prev_blk  = last_blk_ff - 16'd1;
   assign lsc26     = 26'(lsc_ff);
   assign rem_after = rem_ff - lsc26;

   always_comb begin
      active_in   = active_ff;
      cur_in      = cur_ff;
      rem_in      = rem_ff;
      last_blk_in = last_blk_ff;
      lsc_in      = lsc_ff;
      lst_in      = lst_ff;
      emit        = 1'b0;
      res         = '0;
      cnt26       = '0;

      if (pop) begin
         case (ent.cls) inside
            tftc_pkg::CLS_RRQ, tftc_pkg::CLS_WRQ: begin
               last_blk_in = 16'd0;
               emit        = 1'b1;
               if (busy) begin
                  res.reply_kind = tftc_pkg::KIND_ERR;
                  res.error_kind = tftc_pkg::ERR_BUSY;
               end else if (!ent.req_ok) begin
                  active_in      = 1'b0;
                  res.reply_kind = tftc_pkg::KIND_ERR;
                  res.error_kind = ent.req_err;
               end else begin
                  active_in = 1'b1;
                  cur_in    = base26;
                  if (ent.cls == tftc_pkg::CLS_RRQ) begin
                     rem_in           = {1'b0, cfg.file_size_limit};
                     last_blk_in      = 16'd1;
                     cnt26            = chunk({1'b0, cfg.file_size_limit});
                     lsc_in           = cnt26[CNT_W-1:0];
                     res.reply_kind   = tftc_pkg::KIND_DATA;
                     res.reply_block  = 16'd1;
                     res.flash_offset = base26;
                     res.byte_count   = cnt26[9:0];
                  end else begin
                     res.reply_kind = tftc_pkg::KIND_ACK;
                  end
               end
            end

            tftc_pkg::CLS_DATA: begin
               res.reply_kind  = tftc_pkg::KIND_ACK;
               res.reply_block = ent.block_number;
               if (active_ff && ent.block_number == next_blk) begin
                  last_blk_in = ent.block_number;
                  emit        = 1'b1;
                  lst_in      = ent.now_seconds;
                  if (n26 != '0 && too_big) begin
                     // would run past the size limit: abort, nothing written
                     active_in       = 1'b0;
                     lst_in          = lst_ff;
                     res             = '0;
                     res.reply_kind  = tftc_pkg::KIND_ERR;
                     res.error_kind  = tftc_pkg::ERR_BIG;
                  end else begin
                     if (n26 != '0) begin
                        res.write_payload = 1'b1;
                        res.flash_offset  = cur_ff;
                        res.byte_count    = n26[9:0];
                        cur_in            = cur_ff + n26;
                     end
                     if (n26 < PB26) begin
                        active_in = 1'b0;
                     end
                  end
               end else if (ent.block_number == last_blk_ff) begin
                  // duplicate of the last block: acknowledge again
                  emit   = 1'b1;
                  lst_in = ent.now_seconds;
               end
            end

            tftc_pkg::CLS_ACK: begin
               if (active_ff) begin
                  lst_in = ent.now_seconds;
                  if (ent.block_number == last_blk_ff) begin
                     last_blk_in = next_blk;
                     cur_in      = cur_ff + lsc26;
                     rem_in      = rem_after;
                     if (lsc26 == PB26) begin
                        cnt26            = chunk(rem_after);
                        lsc_in           = cnt26[CNT_W-1:0];
                        emit             = 1'b1;
                        res.reply_kind   = tftc_pkg::KIND_DATA;
                        res.reply_block  = next_blk;
                        res.flash_offset = cur_ff + lsc26;
                        res.byte_count   = cnt26[9:0];
                     end else begin
                        active_in = 1'b0;
                     end
                  end else if (ent.block_number == prev_blk) begin
                     // peer missed our last send: resend it
                     cnt26            = chunk(rem_ff);
                     lsc_in           = cnt26[CNT_W-1:0];
                     emit             = 1'b1;
                     res.reply_kind   = tftc_pkg::KIND_DATA;
                     res.reply_block  = last_blk_ff;
                     res.flash_offset = cur_ff;
                     res.byte_count   = cnt26[9:0];
                  end
               end
            end

            default: begin
            end
         endcase
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         cur_ff       <= '0;
         rem_ff       <= '0;
         last_blk_ff  <= '0;
         lsc_ff       <= '0;
         lst_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         cur_ff       <= cur_in;
         rem_ff       <= rem_in;
         last_blk_ff  <= last_blk_in;
         lsc_ff       <= lsc_in;
         lst_ff       <= lst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_idle_ack_silent: assert property (@(posedge clock) disable iff (reset)
      pop && ent.cls == tftc_pkg::CLS_ACK && !active_ff |=> !rsp_valid_ff)
      else $error("ack while idle produced a reply");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.reply_kind == tftc_pkg::KIND_ERR |->
         rsp_ff.flash_offset == '0 && rsp_ff.byte_count == '0 && !rsp_ff.write_payload)
      else $error("error reply carries a flash range");

   a_write_is_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.write_payload |->
         rsp_ff.reply_kind == tftc_pkg::KIND_ACK && rsp_ff.byte_count != '0)
      else $error("payload write without a non-empty ack");

   a_req_restarts: assert property (@(posedge clock) disable iff (reset)
      pop && (ent.cls == tftc_pkg::CLS_RRQ || ent.cls == tftc_pkg::CLS_WRQ) && !busy
         && !ent.req_ok |=> !active_ff)
      else $error("rejected request left a transfer active");
`endif

endmodule

// ===== rtl/tftp_flash_transfer_control_unit.sv =====
// Top level of the TFTP flash transfer control unit: register file and wiring.
// Depends on tftc_pkg, tftc_front, tftc_queue and tftc_back.
//
// Control side of a single-file TFTP server whose image lives in flash. Each
// item on the req_ channel is one decoded packet header (opcode, block
// number, payload length, request check flags, current second); each item on
// the rsp_ channel is one reply: an ACK (optionally committing the DATA
// payload to flash), a DATA send with a flash read range, or an error. Items
// that call for no reply (unknown opcodes, ACK while idle, stale DATA, stray
// ACK) produce nothing. Throughput is one item per clock unless the queue is
// full: the front end classifies an item in the cycle it is accepted and
// writes it into a two-entry queue; the back end retires one queued item per
// clock whenever its output register is empty or being taken, and that
// register holds the reply. The back end's state update (offset adds, size
// compare, busy timer compare) is the loop that sets this rate.
// The registers sit on an APB port at byte addresses 0 (image base offset),
// 4 (file size limit) and 8 (busy timeout in seconds); paddr[1:0] is not
// decoded, and writes to 12-15 are ignored and read as zero. Registers should
// be changed only while no item is in flight.
module tftp_flash_transfer_control_unit #(
   parameter int PAYLOAD_BYTES = 512
) (
   input  logic              clock,
   input  logic              reset,

   // packet header input
   input  logic              req_valid,
   output logic              req_stall,
   input  tftc_pkg::req_type req_data,

   // reply output
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tftc_pkg::rsp_type rsp_data,

   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   // ---------------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------------
   logic [24:0] base_ff, base_in;
   logic [24:0] limit_ff, limit_in;
   logic [7:0]  timeout_ff, timeout_in;
   logic        reg_wr;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign reg_wr  = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      base_in    = base_ff;
      limit_in   = limit_ff;
      timeout_in = timeout_ff;
      if (reg_wr) begin
         unique case (reg_idx)
            tftc_pkg::REG_IMAGE_BASE:   base_in    = pwdata[24:0];
            tftc_pkg::REG_FILE_LIMIT:   limit_in   = pwdata[24:0];
            tftc_pkg::REG_BUSY_TIMEOUT: timeout_in = pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         tftc_pkg::REG_IMAGE_BASE:   prdata = {7'd0, base_ff};
         tftc_pkg::REG_FILE_LIMIT:   prdata = {7'd0, limit_ff};
         tftc_pkg::REG_BUSY_TIMEOUT: prdata = {24'd0, timeout_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         limit_ff   <= tftc_pkg::FILE_LIMIT_RESET;
         timeout_ff <= tftc_pkg::BUSY_TIMEOUT_RESET;
      end else begin
         base_ff    <= base_in;
         limit_ff   <= limit_in;
         timeout_ff <= timeout_in;
      end
   end

   tftc_pkg::cfg_type cfg;

   assign cfg.image_base_offset    = base_ff;
   assign cfg.file_size_limit      = limit_ff;
   assign cfg.busy_timeout_seconds = timeout_ff;

   // ---------------------------------------------------------------------
   // Front end -> queue -> back end
   // ---------------------------------------------------------------------
   logic                q_full;
   logic                q_push;
   tftc_pkg::entry_type q_entry;
   logic                q_pop;
   logic                q_valid;
   tftc_pkg::entry_type q_head;

   tftc_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   tftc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head)
   );

   tftc_back #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .ent_valid (q_valid),
      .ent       (q_head),
      .ent_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/tftp_flash_transfer_control_unit_tb.sv =====
// Self-checking testbench for the TFTP flash transfer control unit.
// Depends on tftc_pkg and the RTL top level; runs directed and random items.
// The replies are predicted in-bench and checked field by field.
`timescale 1ns / 1ps

module tftp_flash_transfer_control_unit_tb;

   localparam int PAYLOAD        = 512;
   localparam int WATCHDOG_LIMIT = 5000;   // cycles with nothing accepted or delivered
   localparam int SETTLE_CYCLES  = 8;      // margin for replyless items to drain
   localparam int PHASE_ITEMS    = 230;

   // One row of the directed plan: either a register setting or an item,
   // the latter with an optional reply typed in by hand
   typedef struct {
      bit                is_cfg;
      logic [24:0]       base;
      logic [24:0]       limit;
      logic [7:0]        timeout;
      tftc_pkg::req_type hdr;
      bit                pinned;
      tftc_pkg::rsp_type want;
   } step_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   tftc_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   tftc_pkg::rsp_type rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [3:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   // Hand-typed reply travelling with the item on the bus
   bit                pin_valid;
   tftc_pkg::rsp_type pin_reply;

   // Register copies as the block should hold them
   logic [24:0] cfg_base;
   logic [24:0] cfg_limit;
   logic [7:0]  cfg_timeout;

   // Transfer state as the block should hold it
   bit          xfer_active;
   logic [25:0] xfer_offset;
   logic [25:0] xfer_left;
   logic [15:0] xfer_block;
   logic [9:0]  send_count;
   logic [31:0] send_time;

   tftc_pkg::rsp_type replies_due[$];
   tftc_pkg::rsp_type predicted;
   bit                has_reply;
   int                fails;
   int                quiet_cycles;
   int                send_idle_pct;
   int                stall_pct;
   logic [31:0]       now_s;          // running clock of the random packets

   tftp_flash_transfer_control_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Size of the next DATA send for what is left of the image
   function automatic logic [9:0] chunk_of(input logic [25:0] left);
      return (left > 26'(PAYLOAD)) ? 10'(PAYLOAD) : left[9:0];
   endfunction

   // Works out the reply to one packet header and moves the transfer state
   // on; returns 0 where the packet calls for no reply
   function automatic bit tftp_reply(input tftc_pkg::req_type h,
                                     output tftc_pkg::rsp_type r);
      logic [15:0] next_block;
      logic [9:0]  n;
      logic [25:0] written;
      logic [31:0] elapsed;
      r          = '0;
      elapsed    = h.now_seconds - send_time;
      next_block = xfer_block + 16'd1;
      n          = (h.payload_length > 10'(PAYLOAD)) ? 10'(PAYLOAD) : h.payload_length;
      written    = xfer_offset - 26'(cfg_base);
      case (h.operation) inside
         tftc_pkg::OP_RRQ, tftc_pkg::OP_WRQ: begin
            // any request clears the block count, even one refused as busy
            xfer_block = '0;
            r.reply_kind = tftc_pkg::KIND_ERR;
            if (xfer_active && elapsed < 32'(cfg_timeout)) begin
               r.error_kind = tftc_pkg::ERR_BUSY;
               return 1'b1;
            end
            xfer_active = 1'b0;
            if (!h.request_terminated) begin
               r.error_kind = tftc_pkg::ERR_SHORT;
               return 1'b1;
            end
            if (!h.mode_is_octet) begin
               r.error_kind = tftc_pkg::ERR_TYPE;
               return 1'b1;
            end
            if (!h.name_matches) begin
               r.error_kind = tftc_pkg::ERR_NAME;
               return 1'b1;
            end
            xfer_active = 1'b1;
            xfer_offset = 26'(cfg_base);
            if (h.operation == tftc_pkg::OP_RRQ) begin
               xfer_left      = 26'(cfg_limit);
               xfer_block     = 16'd1;
               send_count     = chunk_of(xfer_left);
               r.reply_kind   = tftc_pkg::KIND_DATA;
               r.reply_block  = xfer_block;
               r.flash_offset = xfer_offset;
               r.byte_count   = send_count;
            end else begin
               r.reply_kind = tftc_pkg::KIND_ACK;
            end
            return 1'b1;
         end
         tftc_pkg::OP_DATA: begin
            if (xfer_active && h.block_number == next_block) begin
               xfer_block = h.block_number;
               if (n != 0) begin
                  // refuse a payload that would run past the size limit
                  if (27'(written) + 27'(n) > 27'(cfg_limit)) begin
                     xfer_active  = 1'b0;
                     r.reply_kind = tftc_pkg::KIND_ERR;
                     r.error_kind = tftc_pkg::ERR_BIG;
                     return 1'b1;
                  end
                  r.write_payload = 1'b1;
                  r.flash_offset  = xfer_offset;
                  r.byte_count    = n;
                  xfer_offset     = xfer_offset + 26'(n);
               end
               if (n < 10'(PAYLOAD))
                  xfer_active = 1'b0;
            end else if (h.block_number != xfer_block) begin
               return 1'b0;   // stale block, dropped
            end
            send_time     = h.now_seconds;
            r.reply_kind  = tftc_pkg::KIND_ACK;
            r.reply_block = h.block_number;
            return 1'b1;
         end
         tftc_pkg::OP_ACK: begin
            if (!xfer_active)
               return 1'b0;
            send_time = h.now_seconds;
            if (h.block_number == xfer_block) begin
               xfer_block  = xfer_block + 16'd1;
               xfer_offset = xfer_offset + 26'(send_count);
               xfer_left   = xfer_left - 26'(send_count);
               if (send_count != 10'(PAYLOAD)) begin
                  xfer_active = 1'b0;   // short block acknowledged: done
                  return 1'b0;
               end
               send_count = chunk_of(xfer_left);
            end else if (h.block_number != xfer_block - 16'd1) begin
               return 1'b0;   // stray ack, only the timer moves
            end else begin
               send_count = chunk_of(xfer_left);   // resend the last block
            end
            r.reply_kind   = tftc_pkg::KIND_DATA;
            r.reply_block  = xfer_block;
            r.flash_offset = xfer_offset;
            r.byte_count   = send_count;
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic compare_reply(input tftc_pkg::rsp_type want,
                                input tftc_pkg::rsp_type got);
      if (got.reply_kind !== want.reply_kind) begin
         $error("reply_kind: expected %0d, got %0d", want.reply_kind, got.reply_kind);
         fails++;
      end
      if (got.reply_block !== want.reply_block) begin
         $error("reply_block: expected %0d, got %0d", want.reply_block, got.reply_block);
         fails++;
      end
      if (got.error_kind !== want.error_kind) begin
         $error("error_kind: expected %0d, got %0d", want.error_kind, got.error_kind);
         fails++;
      end
      if (got.write_payload !== want.write_payload) begin
         $error("write_payload: expected %0d, got %0d",
                want.write_payload, got.write_payload);
         fails++;
      end
      if (got.flash_offset !== want.flash_offset) begin
         $error("flash_offset: expected %h, got %h", want.flash_offset, got.flash_offset);
         fails++;
      end
      if (got.byte_count !== want.byte_count) begin
         $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
         fails++;
      end
   endtask

   // Both channels are sampled at the rising edge. A reply is checked before
   // the item of the same edge is predicted; as an item passes through the queue
   // and the output register before its reply, the two never refer to each other.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $error("reply with none outstanding: kind %0d block %0d",
                      rsp_data.reply_kind, rsp_data.reply_block);
               fails++;
            end else begin
               compare_reply(replies_due.pop_front(), rsp_data);
            end
         end
         if (req_valid && !req_stall) begin
            has_reply = tftp_reply(req_data, predicted);
            if (pin_valid)
               replies_due.push_back(pin_reply);
            else if (has_reply)
               replies_due.push_back(predicted);
         end
      end
   end

   // Watchdog: a run that stops moving ends as a failure
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver back-pressure, redrawn each cycle
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   function automatic tftc_pkg::req_type hdr(input logic [15:0] op,
                                             input logic [15:0] blk,
                                             input logic [9:0] len,
                                             input logic [2:0] flags,
                                             input logic [31:0] now);
      tftc_pkg::req_type h;
      h.operation      = op;
      h.block_number   = blk;
      h.payload_length = len;
      {h.request_terminated, h.mode_is_octet, h.name_matches} = flags;
      h.now_seconds    = now;
      return h;
   endfunction

   function automatic tftc_pkg::rsp_type reply(input logic [1:0] kind,
                                               input logic [15:0] blk,
                                               input logic [2:0] err, input logic wr,
                                               input logic [25:0] off,
                                               input logic [9:0] cnt);
      tftc_pkg::rsp_type r;
      r.reply_kind    = kind;
      r.reply_block   = blk;
      r.error_kind    = err;
      r.write_payload = wr;
      r.flash_offset  = off;
      r.byte_count    = cnt;
      return r;
   endfunction

   function automatic step_type item_row(input tftc_pkg::req_type h);
      step_type s;
      s        = '{default: '0};
      s.hdr    = h;
      return s;
   endfunction

   function automatic step_type pinned_row(input tftc_pkg::req_type h,
                                           input tftc_pkg::rsp_type w);
      step_type s;
      s        = item_row(h);
      s.pinned = 1'b1;
      s.want   = w;
      return s;
   endfunction

   function automatic step_type settings_row(input logic [24:0] base,
                                             input logic [24:0] limit,
                                             input logic [7:0] timeout);
      step_type s;
      s         = '{default: '0};
      s.is_cfg  = 1'b1;
      s.base    = base;
      s.limit   = limit;
      s.timeout = timeout;
      return s;
   endfunction

   // Random packet, mostly shaped to follow the live transfer so that reads
   // and writes run on for many blocks; a share is noise and broken requests
   function automatic tftc_pkg::req_type random_header();
      tftc_pkg::req_type h;
      int                pick;
      int                sel;
      h.operation      = 16'($urandom);
      h.block_number   = 16'($urandom);
      h.payload_length = 10'($urandom_range(0, PAYLOAD));
      {h.request_terminated, h.mode_is_octet, h.name_matches} = 3'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 3)
         now_s = $urandom;
      else
         now_s = now_s + 32'($urandom_range(0, 4));
      h.now_seconds = now_s;
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 99);
      if (pick < 12) begin
         h.operation          = (pick < 6) ? tftc_pkg::OP_RRQ : tftc_pkg::OP_WRQ;
         h.request_terminated = ($urandom_range(0, 9) != 0);
         h.mode_is_octet      = ($urandom_range(0, 9) != 0);
         h.name_matches       = ($urandom_range(0, 9) != 0);
      end else if (pick < 17) begin
         ;   // noise: whatever was drawn above
      end else if (pick < 58) begin
         h.operation = tftc_pkg::OP_DATA;
         if (sel < 85)
            h.block_number = xfer_block + 16'd1;
         else if (sel < 95)
            h.block_number = xfer_block;
         sel = $urandom_range(0, 99);
         if (sel < 65)
            h.payload_length = 10'(PAYLOAD);
         else if (sel < 92)
            h.payload_length = 10'($urandom_range(0, PAYLOAD - 1));
         else
            h.payload_length = 10'($urandom_range(PAYLOAD + 1, 1023));
      end else begin
         h.operation = tftc_pkg::OP_ACK;
         if (sel < 85)
            h.block_number = xfer_block;
         else if (sel < 93)
            h.block_number = xfer_block - 16'd1;
      end
      return h;
   endfunction

   // Offer one item at the falling edge and hold it until it is taken
   task automatic offer_header(input tftc_pkg::req_type h, input bit pin,
                               input tftc_pkg::rsp_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= h;
      pin_valid <= pin;
      pin_reply <= want;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Let every outstanding reply arrive, then give replyless items in the
   // pipe time to drain; returns at a falling edge
   task automatic settle();
      req_valid <= 1'b0;
      while (replies_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // APB write followed by a read-back of the same register; the bus is
   // left idle before returning at a falling edge
   task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      readback = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      case (idx)
         tftc_pkg::REG_IMAGE_BASE:   cfg_base    = value[24:0];
         tftc_pkg::REG_FILE_LIMIT:   cfg_limit   = value[24:0];
         tftc_pkg::REG_BUSY_TIMEOUT: cfg_timeout = value[7:0];
         default: ;
      endcase
      if (readback !== value) begin
         $error("prdata: expected %h, got %h", value, readback);
         fails++;
      end
   endtask

   task automatic apply_settings(input logic [24:0] base, input logic [24:0] limit,
                                 input logic [7:0] timeout);
      settle();
      write_register(tftc_pkg::REG_IMAGE_BASE, 32'(base));
      write_register(tftc_pkg::REG_FILE_LIMIT, 32'(limit));
      write_register(tftc_pkg::REG_BUSY_TIMEOUT, 32'(timeout));
   endtask

   // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both, lightly
   task automatic set_idling(input int mode);
      case (mode)
         1:       begin send_idle_pct = 66; stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  stall_pct = 66; end
         3:       begin send_idle_pct = 8;  stall_pct = 8;  end
         default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      step_type          plan[$];
      tftc_pkg::req_type h;
      int                phase;
      int                counted;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      pin_valid = 1'b0;
      pin_reply = '0;
      fails     = 0;
      now_s     = '0;
      set_idling(0);

      // state after reset, as the block should come up
      cfg_base    = '0;
      cfg_limit   = tftc_pkg::FILE_LIMIT_RESET;
      cfg_timeout = tftc_pkg::BUSY_TIMEOUT_RESET;
      xfer_active = 1'b0;
      xfer_offset = '0;
      xfer_left   = '0;
      xfer_block  = '0;
      send_count  = '0;
      send_time   = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Flags are {terminated, octet, name}.
      plan = {
         // ignored while idle: unknown opcode, ack, data
         item_row(hdr(16'hFFFF, 16'hFFFF, 10'h3FF, 3'b111, 32'hFFFF_FFFF)),
         item_row(hdr(tftc_pkg::OP_ACK, 16'd0, 10'd0, 3'b000, 32'd0)),
         item_row(hdr(tftc_pkg::OP_DATA, 16'd1, 10'd512, 3'b000, 32'd0)),
         // request checks in order: short, mode, name
         pinned_row(hdr(tftc_pkg::OP_RRQ, 16'd0, 10'd0, 3'b000, 32'd10),
                    reply(tftc_pkg::KIND_ERR, 16'd0, tftc_pkg::ERR_SHORT,
                          1'b0, 26'd0, 10'd0)),
         pinned_row(hdr(tftc_pkg::OP_WRQ, 16'd0, 10'd0, 3'b100, 32'd11),
                    reply(tftc_pkg::KIND_ERR, 16'd0, tftc_pkg::ERR_TYPE,
                          1'b0, 26'd0, 10'd0)),
         pinned_row(hdr(tftc_pkg::OP_RRQ, 16'd0, 10'd0, 3'b110, 32'd12),
                    reply(tftc_pkg::KIND_ERR, 16'd0, tftc_pkg::ERR_NAME,
                          1'b0, 26'd0, 10'd0)),
         // read of the default image
         pinned_row(hdr(tftc_pkg::OP_RRQ, 16'd0, 10'd0, 3'b111, 32'd100),
                    reply(tftc_pkg::KIND_DATA, 16'd1, tftc_pkg::ERR_BUSY,
                          1'b0, 26'd0, 10'd512)),
         item_row(hdr(tftc_pkg::OP_ACK, 16'd1, 10'd0, 3'b000, 32'hFFFF_FFF0)),
         // busy across the wrap of the seconds counter
         pinned_row(hdr(tftc_pkg::OP_WRQ, 16'd0, 10'd0, 3'b111, 32'd5),
                    reply(tftc_pkg::KIND_ERR, 16'd0, tftc_pkg::ERR_BUSY,
                          1'b0, 26'd0, 10'd0)),
         // block count cleared: ack for block minus one wraps to 0xFFFF
         item_row(hdr(tftc_pkg::OP_ACK, 16'hFFFF, 10'd0, 3'b000, 32'd6)),
         item_row(hdr(tftc_pkg::OP_ACK, 16'd0, 10'd0, 3'b000, 32'd7)),
         item_row(hdr(tftc_pkg::OP_ACK, 16'd9, 10'd0, 3'b000, 32'd40)),   // stray
         // timeout expired exactly: write request taken over
         pinned_row(hdr(tftc_pkg::OP_WRQ, 16'd0, 10'd0, 3'b111, 32'd70),
                    reply(tftc_pkg::KIND_ACK, 16'd0, tftc_pkg::ERR_BUSY,
                          1'b0, 26'd0, 10'd0)),
         item_row(hdr(tftc_pkg::OP_DATA, 16'd1, 10'h3FF, 3'b000, 32'd71)),   // saturates
         item_row(hdr(tftc_pkg::OP_DATA, 16'd1, 10'd0, 3'b000, 32'd72)),     // duplicate
         item_row(hdr(tftc_pkg::OP_DATA, 16'd7, 10'd512, 3'b000, 32'd73)),   // stale
         item_row(hdr(tftc_pkg::OP_DATA, 16'd2, 10'd0, 3'b000, 32'd74)),     // empty, ends
         // top of flash, small limit, no busy window
         settings_row(25'h1FF_FFFF, 25'd1000, 8'd0),
         pinned_row(hdr(tftc_pkg::OP_WRQ, 16'd0, 10'd0, 3'b111, 32'd0),
                    reply(tftc_pkg::KIND_ACK, 16'd0, tftc_pkg::ERR_BUSY,
                          1'b0, 26'd0, 10'd0)),
         item_row(hdr(tftc_pkg::OP_DATA, 16'd1, 10'd512, 3'b000, 32'd1)),
         pinned_row(hdr(tftc_pkg::OP_DATA, 16'd2, 10'd512, 3'b000, 32'd2),
                    reply(tftc_pkg::KIND_ERR, 16'd0, tftc_pkg::ERR_BIG,
                          1'b0, 26'd0, 10'd0)),
         pinned_row(hdr(tftc_pkg::OP_RRQ, 16'd0, 10'd0, 3'b111, 32'd3),
                    reply(tftc_pkg::KIND_DATA, 16'd1, tftc_pkg::ERR_BUSY,
                          1'b0, 26'h1FF_FFFF, 10'd512)),
         item_row(hdr(tftc_pkg::OP_ACK, 16'd1, 10'd0, 3'b000, 32'd4)),
         item_row(hdr(tftc_pkg::OP_ACK, 16'd2, 10'd0, 3'b000, 32'd5)),   // short, ends
         // empty image, longest busy window
         settings_row(25'd0, 25'd0, 8'd255),
         pinned_row(hdr(tftc_pkg::OP_RRQ, 16'd0, 10'd0, 3'b111, 32'd6),
                    reply(tftc_pkg::KIND_DATA, 16'd1, tftc_pkg::ERR_BUSY,
                          1'b0, 26'd0, 10'd0)),
         item_row(hdr(tftc_pkg::OP_ACK, 16'd1, 10'd0, 3'b000, 32'd7))
      };
      foreach (plan[i]) begin
         if (plan[i].is_cfg)
            apply_settings(plan[i].base, plan[i].limit, plan[i].timeout);
         else
            offer_header(plan[i].hdr, plan[i].pinned, plan[i].want);
      end

      // Random part, one register setting and one idling pattern per phase
      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       apply_settings(25'd0, 25'h1FF_FFFF, 8'd255);
            1:       apply_settings(25'h1FF_FFFF, 25'd0, 8'd0);
            default: apply_settings(25'($urandom), 25'($urandom_range(0, 4096)),
                                    8'($urandom_range(0, 255)));
         endcase
         set_idling(phase % 4);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            h = random_header();
            if (h.operation >= tftc_pkg::OP_RRQ && h.operation <= tftc_pkg::OP_ACK)
               counted++;
            offer_header(h, 1'b0, '0);
         end
      end

      settle();
      if (fails == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== tftp_flash_transfer_control_unit.f =====
rtl/tftc_pkg.sv
rtl/tftc_front.sv
rtl/tftc_queue.sv
rtl/tftc_back.sv
rtl/tftp_flash_transfer_control_unit.sv
test/tftp_flash_transfer_control_unit_tb.sv
